/* hw/rtl/rgb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pkg: shared types and constants
// Record grouping block: ASCII codes, status codes, hash constants, field widths.
// ----------------------------------------------------------------------------
package rgb_pkg;

  localparam int TEMP_W  = 11;
  localparam int COUNT_W = 32;
  localparam int SUM_W   = 64;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_LOW_MUL = 64'd435;
  localparam int          FNV_SHIFT   = 40;

  localparam logic [9:0] TEMP_SAT = 10'd999;

  // Record summary handed from the parser to the lookup engine.
  typedef struct packed {
    logic                     fire;
    logic                     too_long;
    logic signed [TEMP_W-1:0] temp;
  } rec_t;

endpackage

/* hw/rtl/rgb_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_parser: record byte parser
// Buffers name bytes, folds them into the FNV-1a hash and builds the temperature.
// ----------------------------------------------------------------------------
module rgb_parser #(
  parameter int MAX_NAME_BYTES = 32,
  parameter int HASH_BITS      = 64
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        accept,
  input  logic [7:0]                                  in_byte,
  output rgb_pkg::rec_t                               rec,
  output logic [HASH_BITS-1:0]                        rec_hash,
  output logic [$clog2(MAX_NAME_BYTES+2)-1:0]         rec_len,
  output logic [7:0]                                  name_buf [MAX_NAME_BYTES]
);

  localparam int LW = $clog2(MAX_NAME_BYTES + 2);
  localparam int BW = $clog2(MAX_NAME_BYTES);
  localparam logic [1:0] PH_NAME = 2'd0;
  localparam logic [1:0] PH_TEMP = 2'd1;
  localparam logic [1:0] PH_LONG = 2'd3;

  logic [1:0]           phase;
  logic [LW-1:0]        len;
  logic [HASH_BITS-1:0] hash;
  logic [9:0]           accum;
  logic                 neg;
  logic [63:0]          mix;
  logic [63:0]          prod;
  logic [13:0]          acc_wide;
  logic signed [rgb_pkg::TEMP_W-1:0] temp_val;

  // Multiply by the FNV prime as a 40-bit shift plus a small constant product.
  assign mix      = 64'(hash) ^ {56'd0, in_byte};
  assign prod     = (mix << rgb_pkg::FNV_SHIFT) + mix * rgb_pkg::FNV_LOW_MUL;
  assign acc_wide = {4'd0, accum} * 14'd10 + {10'd0, in_byte[3:0]};
  assign temp_val = neg ? -$signed({1'b0, accum}) : $signed({1'b0, accum});

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_NAME;
      len      <= '0;
      hash     <= rgb_pkg::FNV_BASIS[HASH_BITS-1:0];
      accum    <= '0;
      neg      <= 1'b0;
      rec.fire <= 1'b0;
    end else begin
      rec.fire <= 1'b0;
      if (accept) begin
        if (phase == PH_NAME) begin
          if (in_byte == rgb_pkg::CH_NL) begin
            len  <= '0;
            hash <= rgb_pkg::FNV_BASIS[HASH_BITS-1:0];
          end else if (in_byte == rgb_pkg::CH_SEMI) begin
            phase <= (len > LW'(MAX_NAME_BYTES)) ? PH_LONG : PH_TEMP;
          end else begin
            hash <= prod[HASH_BITS-1:0];
            if (len <= LW'(MAX_NAME_BYTES)) len <= len + 1'b1;
          end
        end else if (in_byte == rgb_pkg::CH_NL) begin
          rec.fire     <= 1'b1;
          rec.too_long <= (phase == PH_LONG);
          rec.temp     <= temp_val;
          rec_hash     <= hash;
          rec_len      <= len;
          phase        <= PH_NAME;
          len          <= '0;
          hash         <= rgb_pkg::FNV_BASIS[HASH_BITS-1:0];
          accum        <= '0;
          neg          <= 1'b0;
        end else if (in_byte == rgb_pkg::CH_MINUS) begin
          neg <= 1'b1;
        end else if (in_byte >= rgb_pkg::CH_ZERO && in_byte <= rgb_pkg::CH_NINE) begin
          accum <= (acc_wide > 14'(rgb_pkg::TEMP_SAT)) ? rgb_pkg::TEMP_SAT : acc_wide[9:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_NAME && in_byte != rgb_pkg::CH_NL &&
        in_byte != rgb_pkg::CH_SEMI && len < LW'(MAX_NAME_BYTES)) begin
      name_buf[len[BW-1:0]] <= in_byte;
    end
  end

endmodule

/* hw/rtl/rgb_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_engine: lookup and update sequencer
// Probes the slot table, compares or copies names, updates station statistics.
// ----------------------------------------------------------------------------
module rgb_engine #(
  parameter int TABLE_SLOTS    = 512,
  parameter int MAX_STATIONS   = 128,
  parameter int MAX_NAME_BYTES = 32,
  parameter int HASH_BITS      = 64
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  rgb_pkg::rec_t                             rec,
  input  logic [HASH_BITS-1:0]                      rec_hash,
  input  logic [$clog2(MAX_NAME_BYTES+2)-1:0]       rec_len,
  input  logic [7:0]                                name_buf [MAX_NAME_BYTES],
  output logic                                      busy,
  output logic                                      valid,
  output logic [$clog2(MAX_STATIONS)-1:0]           station_index,
  output logic                                      is_new,
  output logic signed [rgb_pkg::TEMP_W-1:0]         temperature,
  output logic signed [rgb_pkg::TEMP_W-1:0]         min_temp,
  output logic signed [rgb_pkg::TEMP_W-1:0]         max_temp,
  output logic [rgb_pkg::COUNT_W-1:0]               sample_count,
  output logic signed [rgb_pkg::SUM_W-1:0]          temp_sum,
  output logic [1:0]                                status
);

  localparam int SW  = $clog2(TABLE_SLOTS);
  localparam int IW  = $clog2(MAX_STATIONS);
  localparam int TW  = $clog2(MAX_STATIONS + 1);
  localparam int LW  = $clog2(MAX_NAME_BYTES + 2);
  localparam int BW  = $clog2(MAX_NAME_BYTES);
  localparam int NW  = $clog2(MAX_STATIONS * MAX_NAME_BYTES);
  localparam int PW  = SW + 1;
  localparam int TMW = rgb_pkg::TEMP_W;
  localparam int SLW = 1 + HASH_BITS + IW;
  localparam int STW = 2 * TMW + rgb_pkg::COUNT_W + rgb_pkg::SUM_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_PRB  = 3'd2;
  localparam logic [2:0] S_SLOT = 3'd3;
  localparam logic [2:0] S_NRD  = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_COPY = 3'd6;
  localparam logic [2:0] S_UPD  = 3'd7;

  logic [SLW-1:0] slot_mem [TABLE_SLOTS];
  logic [7:0]     name_mem [MAX_STATIONS * MAX_NAME_BYTES];
  logic [LW-1:0]  nlen_mem [MAX_STATIONS];
  logic [STW-1:0] stat_mem [MAX_STATIONS];

  logic [2:0]           state;
  logic [SW-1:0]        idx;
  logic [PW-1:0]        probes;
  logic [TW-1:0]        total;
  logic [IW-1:0]        st;
  logic [LW-1:0]        cnt;
  logic                 fresh;
  logic [HASH_BITS-1:0] h_q;
  logic [LW-1:0]        l_q;
  logic signed [TMW-1:0] t_q;

  logic [SLW-1:0] slot_q;
  logic [7:0]     name_q;
  logic [LW-1:0]  nlen_q;
  logic [STW-1:0] stat_q;

  logic                 slot_v;
  logic [HASH_BITS-1:0] slot_h;
  logic [IW-1:0]        slot_s;
  logic [NW-1:0]        name_addr;

  logic signed [TMW-1:0]             old_min, old_max, new_min, new_max;
  logic [rgb_pkg::COUNT_W-1:0]       old_cnt, new_cnt;
  logic signed [rgb_pkg::SUM_W-1:0]  old_sum, new_sum;

  assign {slot_v, slot_h, slot_s} = slot_q;
  assign name_addr = NW'(st) * NW'(MAX_NAME_BYTES) + NW'(cnt);
  // A record waiting to be taken also blocks input, so the parser cannot
  // overwrite the name buffer before the lookup is done with it.
  assign busy      = (state != S_IDLE) || rec.fire;

  assign {old_min, old_max, old_cnt, old_sum} = stat_q;
  assign new_min = (fresh || t_q < old_min) ? t_q : old_min;
  assign new_max = (fresh || t_q > old_max) ? t_q : old_max;
  assign new_cnt = fresh ? rgb_pkg::COUNT_W'(1) :
                   ((&old_cnt) ? old_cnt : old_cnt + 1'b1);
  assign new_sum = (fresh ? '0 : old_sum) + rgb_pkg::SUM_W'(t_q);

  // Memory reads, registered, at the current sequencer addresses.
  always_ff @(posedge clk) begin
    slot_q <= slot_mem[idx];
    name_q <= name_mem[name_addr];
    nlen_q <= nlen_mem[st];
    stat_q <= stat_mem[st];
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      slot_mem[idx] <= '0;
    end else if (state == S_SLOT && !slot_v && total < TW'(MAX_STATIONS)) begin
      slot_mem[idx] <= {1'b1, h_q, total[IW-1:0]};
    end
    if (state == S_COPY) begin
      if (cnt == l_q) nlen_mem[st] <= l_q;
      else name_mem[name_addr] <= name_buf[cnt[BW-1:0]];
    end
    if (state == S_UPD) stat_mem[st] <= {new_min, new_max, new_cnt, new_sum};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLR;
      idx    <= '0;
      total  <= '0;
      valid  <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_CLR: begin
          idx <= idx + 1'b1;
          if (idx == SW'(TABLE_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (rec.fire) begin
            h_q    <= rec_hash;
            l_q    <= rec_len;
            t_q    <= rec.temp;
            idx    <= rec_hash[SW-1:0];
            probes <= '0;
            if (rec.too_long) begin
              valid         <= 1'b1;
              status        <= rgb_pkg::ST_LONG;
              temperature   <= rec.temp;
              station_index <= '0;
              is_new        <= 1'b0;
              min_temp      <= '0;
              max_temp      <= '0;
              sample_count  <= '0;
              temp_sum      <= '0;
            end else begin
              state <= S_PRB;
            end
          end
        end
        S_PRB: state <= S_SLOT;
        S_SLOT: begin
          cnt <= '0;
          if (!slot_v) begin
            if (total < TW'(MAX_STATIONS)) begin
              st    <= total[IW-1:0];
              fresh <= 1'b1;
              total <= total + 1'b1;
              state <= S_COPY;
            end else begin
              valid         <= 1'b1;
              status        <= rgb_pkg::ST_FULL;
              temperature   <= t_q;
              station_index <= '0;
              is_new        <= 1'b0;
              min_temp      <= '0;
              max_temp      <= '0;
              sample_count  <= '0;
              temp_sum      <= '0;
              state         <= S_IDLE;
            end
          end else if (slot_h == h_q) begin
            st    <= slot_s;
            state <= S_NRD;
          end else if (probes == PW'(TABLE_SLOTS - 1)) begin
            valid         <= 1'b1;
            status        <= rgb_pkg::ST_FULL;
            temperature   <= t_q;
            station_index <= '0;
            is_new        <= 1'b0;
            min_temp      <= '0;
            max_temp      <= '0;
            sample_count  <= '0;
            temp_sum      <= '0;
            state         <= S_IDLE;
          end else begin
            probes <= probes + 1'b1;
            idx    <= idx + 1'b1;
            state  <= S_PRB;
          end
        end
        S_NRD: state <= S_CMP;
        S_CMP: begin
          if (nlen_q == l_q && cnt == l_q) begin
            fresh <= 1'b0;
            state <= S_UPD;
          end else if (nlen_q != l_q || name_q != name_buf[cnt[BW-1:0]]) begin
            if (probes == PW'(TABLE_SLOTS - 1)) begin
              valid         <= 1'b1;
              status        <= rgb_pkg::ST_FULL;
              temperature   <= t_q;
              station_index <= '0;
              is_new        <= 1'b0;
              min_temp      <= '0;
              max_temp      <= '0;
              sample_count  <= '0;
              temp_sum      <= '0;
              state         <= S_IDLE;
            end else begin
              probes <= probes + 1'b1;
              idx    <= idx + 1'b1;
              state  <= S_PRB;
            end
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_NRD;
          end
        end
        S_COPY: begin
          if (cnt == l_q) state <= S_UPD;
          else cnt <= cnt + 1'b1;
        end
        S_UPD: begin
          valid         <= 1'b1;
          status        <= rgb_pkg::ST_OK;
          temperature   <= t_q;
          station_index <= st;
          is_new        <= fresh;
          min_temp      <= new_min;
          max_temp      <= new_max;
          sample_count  <= new_cnt;
          temp_sum      <= new_sum;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fire_idle: assert property (@(posedge clk) disable iff (rst)
    rec.fire |-> state == S_IDLE) else $error("record arrived while engine busy");
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    total <= TW'(MAX_STATIONS)) else $error("station count overflow");
  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    (valid && status == rgb_pkg::ST_OK) |-> sample_count != '0)
    else $error("ok result with zero count");
  a_new_one: assert property (@(posedge clk) disable iff (rst)
    (valid && is_new) |-> sample_count == rgb_pkg::COUNT_W'(1))
    else $error("new station without count of one");
`endif

endmodule

/* hw/rtl/record_group_by_min_max_sum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_group_by_min_max_sum: per-station min, max, count and sum
// Parses "name;temp" text records and aggregates statistics per station name.
// ----------------------------------------------------------------------------
// A byte transfer happens on a clock edge where start is high and busy is low.
// Name and temperature bytes never raise busy. The newline that ends a record
// hands it to the lookup sequencer, which keeps busy high while it works: it
// takes the record over, probes the slot table (states S_PRB and S_SLOT per
// probe), on a hash hit compares the stored name byte by byte and then confirms
// the length, on an insert of a new station copies the name bytes and then the
// name length, and finally updates the statistics. The result is shown for
// exactly one cycle with valid high; the receiver cannot stall it, so it must
// take every result as it comes. After reset the block sweeps the slot table
// clear, holding busy until every slot is cleared, before it takes the first
// byte. A status of 1 means the table is full, 2 that the name was longer than
// MAX_NAME_BYTES; in both cases no statistics change.
// ----------------------------------------------------------------------------
module record_group_by_min_max_sum #(
  parameter int TABLE_SLOTS    = 512,
  parameter int MAX_STATIONS   = 128,
  parameter int MAX_NAME_BYTES = 32,
  parameter int HASH_BITS      = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [7:0]                        in_byte,
  output logic                              valid,
  output logic [$clog2(MAX_STATIONS)-1:0]   station_index,
  output logic                              is_new,
  output logic signed [10:0]                temperature,
  output logic signed [10:0]                min_temp,
  output logic signed [10:0]                max_temp,
  output logic [31:0]                       sample_count,
  output logic signed [63:0]                temp_sum,
  output logic [1:0]                        status
);

  rgb_pkg::rec_t                       rec;
  logic [HASH_BITS-1:0]                rec_hash;
  logic [$clog2(MAX_NAME_BYTES+2)-1:0] rec_len;
  logic [7:0]                          name_buf [MAX_NAME_BYTES];

  rgb_parser #(
    .MAX_NAME_BYTES(MAX_NAME_BYTES),
    .HASH_BITS     (HASH_BITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (start && !busy),
    .in_byte (in_byte),
    .rec     (rec),
    .rec_hash(rec_hash),
    .rec_len (rec_len),
    .name_buf(name_buf)
  );

  rgb_engine #(
    .TABLE_SLOTS   (TABLE_SLOTS),
    .MAX_STATIONS  (MAX_STATIONS),
    .MAX_NAME_BYTES(MAX_NAME_BYTES),
    .HASH_BITS     (HASH_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .rec          (rec),
    .rec_hash     (rec_hash),
    .rec_len      (rec_len),
    .name_buf     (name_buf),
    .busy         (busy),
    .valid        (valid),
    .station_index(station_index),
    .is_new       (is_new),
    .temperature  (temperature),
    .min_temp     (min_temp),
    .max_temp     (max_temp),
    .sample_count (sample_count),
    .temp_sum     (temp_sum),
    .status       (status)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: record grouping regression
// Streams "name;temp" records into the station grouping block and checks every
// reported record against a software copy of the station table and statistics.
// ----------------------------------------------------------------------------

// One expected record report, at the widths of the block's result ports.
typedef struct {
  logic [6:0]         station;
  logic               fresh;
  logic signed [10:0] temp;
  logic signed [10:0] tmin;
  logic signed [10:0] tmax;
  logic [31:0]        count;
  logic signed [63:0] sum;
  logic [1:0]         status;
} station_report_t;

// The scoreboard keeps its own station table. Each accepted byte is folded into
// it, and every newline that closes a record queues the report it should give.
class station_stats_board;
  localparam int SLOTS    = 512;
  localparam int STATIONS = 128;
  localparam int NAME_MAX = 32;
  localparam logic [63:0] HASH_MUL = 64'h100000001b3;
  typedef enum int {PH_NAME, PH_TEMP, PH_TEMP_LONG} phase_e;

  bit          slot_used [SLOTS];
  logic [63:0] slot_key [SLOTS];
  int          slot_owner [SLOTS];
  logic [7:0]  known_name [STATIONS][NAME_MAX];
  int          known_len [STATIONS];
  int          low_temp [STATIONS];
  int          high_temp [STATIONS];
  logic [31:0] seen [STATIONS];
  logic [63:0] total_tenths [STATIONS];
  int          station_count;
  logic [7:0]  pending_name [NAME_MAX];
  int          pending_len;
  logic [63:0] name_hash;
  phase_e      phase;
  int          tenths;
  bit          negative;
  station_report_t expected_reports[$];
  int          errors;

  function new();
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 0;
    for (int i = 0; i < STATIONS; i++) begin
      low_temp[i] = 32767;
      high_temp[i] = -32768;
      seen[i] = 0;
      total_tenths[i] = 0;
    end
    station_count = 0;
    errors = 0;
    clear_record();
  endfunction

  function void clear_record();
    pending_len = 0;
    name_hash = rgb_pkg::FNV_BASIS;
    phase = PH_NAME;
    tenths = 0;
    negative = 0;
  endfunction

  function bit same_name(int st);
    if (known_len[st] != pending_len) return 0;
    for (int i = 0; i < pending_len; i++)
      if (known_name[st][i] != pending_name[i]) return 0;
    return 1;
  endfunction

  // Linear probe from hash mod SLOTS; returns the status code of the lookup.
  function logic [1:0] find_station(output int st, output bit fresh);
    int idx;
    idx = int'(name_hash % SLOTS);
    st = 0;
    fresh = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (!slot_used[idx]) begin
        if (station_count >= STATIONS) return rgb_pkg::ST_FULL;
        slot_used[idx] = 1;
        slot_key[idx] = name_hash;
        slot_owner[idx] = station_count;
        for (int i = 0; i < pending_len; i++) known_name[station_count][i] = pending_name[i];
        known_len[station_count] = pending_len;
        st = station_count;
        fresh = 1;
        station_count++;
        return rgb_pkg::ST_OK;
      end
      if (slot_key[idx] == name_hash && same_name(slot_owner[idx])) begin
        st = slot_owner[idx];
        return rgb_pkg::ST_OK;
      end
      idx = (idx + 1) % SLOTS;
    end
    return rgb_pkg::ST_FULL;
  endfunction

  function void note_byte(logic [7:0] b);
    station_report_t r;
    int st;
    bit fresh;
    int t;
    if (phase == PH_NAME) begin
      if (b == rgb_pkg::CH_NL) begin
        clear_record();
      end else if (b == rgb_pkg::CH_SEMI) begin
        phase = (pending_len > NAME_MAX) ? PH_TEMP_LONG : PH_TEMP;
      end else begin
        name_hash = (name_hash ^ {56'd0, b}) * HASH_MUL;
        if (pending_len < NAME_MAX) pending_name[pending_len] = b;
        if (pending_len <= NAME_MAX) pending_len++;
      end
      return;
    end
    if (b != rgb_pkg::CH_NL) begin
      if (b == rgb_pkg::CH_MINUS) begin
        negative = 1;
      end else if (b >= rgb_pkg::CH_ZERO && b <= rgb_pkg::CH_NINE) begin
        tenths = tenths * 10 + int'(b - rgb_pkg::CH_ZERO);
        if (tenths > 999) tenths = 999;
      end
      return;
    end
    t = negative ? -tenths : tenths;
    r = '{default: 0};
    r.temp = 11'(t);
    if (phase == PH_TEMP_LONG) r.status = rgb_pkg::ST_LONG;
    else r.status = find_station(st, fresh);
    if (r.status == rgb_pkg::ST_OK) begin
      if (t < low_temp[st]) low_temp[st] = t;
      if (t > high_temp[st]) high_temp[st] = t;
      if (seen[st] != 32'hffffffff) seen[st]++;
      total_tenths[st] += 64'(signed'(t));
      r.station = 7'(st);
      r.fresh = fresh;
      r.tmin = 11'(low_temp[st]);
      r.tmax = 11'(high_temp[st]);
      r.count = seen[st];
      r.sum = total_tenths[st];
    end
    expected_reports.push_back(r);
    clear_record();
  endfunction

  function void check_result(station_report_t got);
    station_report_t w;
    if (expected_reports.size() == 0) begin
      $display("%0t: unexpected report, station %0d status %0d", $time, got.station,
               got.status);
      errors++;
      return;
    end
    w = expected_reports.pop_front();
    if (got.station !== w.station) begin
      $display("%0t: station_index expected %0d actual %0d", $time, w.station, got.station);
      errors++;
    end
    if (got.fresh !== w.fresh) begin
      $display("%0t: is_new expected %0d actual %0d", $time, w.fresh, got.fresh);
      errors++;
    end
    if (got.temp !== w.temp) begin
      $display("%0t: temperature expected %0d actual %0d", $time, w.temp, got.temp);
      errors++;
    end
    if (got.tmin !== w.tmin) begin
      $display("%0t: min_temp expected %0d actual %0d", $time, w.tmin, got.tmin);
      errors++;
    end
    if (got.tmax !== w.tmax) begin
      $display("%0t: max_temp expected %0d actual %0d", $time, w.tmax, got.tmax);
      errors++;
    end
    if (got.count !== w.count) begin
      $display("%0t: sample_count expected %0d actual %0d", $time, w.count, got.count);
      errors++;
    end
    if (got.sum !== w.sum) begin
      $display("%0t: temp_sum expected %0d actual %0d", $time, w.sum, got.sum);
      errors++;
    end
    if (got.status !== w.status) begin
      $display("%0t: status expected %0d actual %0d", $time, w.status, got.status);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam int NAME_POOL = 170;

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic [7:0]         in_byte = 8'd0;
  logic               busy;
  logic               valid;
  logic [6:0]         station_index;
  logic               is_new;
  logic signed [10:0] temperature;
  logic signed [10:0] min_temp;
  logic signed [10:0] max_temp;
  logic [31:0]        sample_count;
  logic signed [63:0] temp_sum;
  logic [1:0]         status;

  station_stats_board board;

  // Random station names, drawn once; more names than the table can hold, so
  // that station indices spread over most of the table.
  logic [7:0] pool_name [NAME_POOL][$];

  // Sender burst bookkeeping: bytes left in the current burst.
  int burst_left = 0;

  always #2 clk = ~clk;

  record_group_by_min_max_sum i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_byte(in_byte),
    .valid(valid), .station_index(station_index), .is_new(is_new),
    .temperature(temperature), .min_temp(min_temp), .max_temp(max_temp),
    .sample_count(sample_count), .temp_sum(temp_sum), .status(status)
  );

  // Results cannot be held off, so the monitor takes every strobe as it comes.
  always @(posedge clk) begin
    station_report_t got;
    if (!rst && valid) begin
      got.station = station_index;
      got.fresh = is_new;
      got.temp = temperature;
      got.tmin = min_temp;
      got.tmax = max_temp;
      got.count = sample_count;
      got.sum = temp_sum;
      got.status = status;
      board.check_result(got);
    end
  end

  // Present one byte and hold start until the transfer happens. Between bursts
  // the sender drops start for a random number of cycles; within a burst start
  // stays high from one byte to the next, so it is never lowered and raised in
  // the same step.
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 30);
    end
    in_byte <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_byte(b);
    burst_left--;
  endtask

  task automatic send_text(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // A temperature in tenths, written in the usual -?d.d / -?dd.d form.
  task automatic send_temp(input int v);
    int a;
    a = (v < 0) ? -v : v;
    if (v < 0) send_byte(rgb_pkg::CH_MINUS);
    if (a >= 100) send_byte(rgb_pkg::CH_ZERO + 8'(a / 100));
    send_byte(rgb_pkg::CH_ZERO + 8'((a / 10) % 10));
    send_byte(CH_DOT);
    send_byte(rgb_pkg::CH_ZERO + 8'(a % 10));
  endtask

  task automatic send_record(input logic [7:0] nm[$], input int v);
    send_text(nm);
    send_byte(rgb_pkg::CH_SEMI);
    send_temp(v);
    send_byte(rgb_pkg::CH_NL);
  endtask

  // A byte that is neither newline nor semicolon, to keep a name intact.
  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == rgb_pkg::CH_NL || b == rgb_pkg::CH_SEMI);
    return b;
  endfunction

  function automatic void fill_name(ref logic [7:0] q[$], input int len);
    q.delete();
    for (int i = 0; i < len; i++) q.push_back(name_byte());
  endfunction

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (board.expected_reports.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] nm[$];
    logic [7:0] junk[$];
    int pick;
    int kind;
    board = new();
    for (int i = 0; i < NAME_POOL; i++) fill_name(pool_name[i], $urandom_range(1, 12));
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed records: temperature extremes, a repeated station, an empty
    // name, names at and just past the length limit, an empty line, stray
    // bytes inside the temperature, and a saturating temperature.
    send_record(pool_name[0], 999);
    send_record(pool_name[0], -999);
    send_record(pool_name[0], 0);
    nm.delete();
    send_record(nm, -5);
    send_record(nm, 123);
    fill_name(nm, 32);
    send_record(nm, 450);
    send_record(nm, -451);
    fill_name(nm, 33);
    send_record(nm, 77);
    fill_name(nm, 40);
    send_record(nm, -1);
    send_byte(rgb_pkg::CH_NL);
    send_text(pool_name[1]);
    send_byte(rgb_pkg::CH_NL);
    junk = '{8'hff, 8'h00, rgb_pkg::CH_SEMI, 8'h7f, CH_DOT, 8'h80};
    send_text(pool_name[2]);
    send_byte(rgb_pkg::CH_SEMI);
    send_byte(8'h31);
    send_text(junk);
    send_byte(8'h32);
    send_byte(rgb_pkg::CH_NL);
    send_text(pool_name[3]);
    send_text('{rgb_pkg::CH_SEMI, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39,
                rgb_pkg::CH_MINUS, rgb_pkg::CH_NL});

    // Let every report come back before the random part starts.
    drain();

    for (int r = 0; r < 140; r++) begin
      kind = $urandom_range(0, 99);
      pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NAME_POOL - 1)
                                         : $urandom_range(0, 90);
      if (kind < 82) begin
        send_record(pool_name[pick], $urandom_range(0, 1998) - 999);
      end else if (kind < 86) begin
        fill_name(nm, $urandom_range(33, 45));
        send_record(nm, $urandom_range(0, 1998) - 999);
      end else if (kind < 91) begin
        // Broken line: part of a name dropped by a newline.
        send_text(pool_name[pick]);
        send_byte(rgb_pkg::CH_NL);
      end else begin
        // Record whose temperature carries arbitrary bytes.
        send_text(pool_name[pick]);
        send_byte(rgb_pkg::CH_SEMI);
        repeat ($urandom_range(0, 6)) begin
          logic [7:0] b;
          do b = 8'($urandom_range(0, 255)); while (b == rgb_pkg::CH_NL);
          send_byte(b);
        end
        send_byte(rgb_pkg::CH_NL);
      end
      if (r == 70) drain();
    end

    drain();
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.expected_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
